FILE: hdl/gwh_pkg.sv
// gwh_pkg: shared sizes, command and register codes, word types and the
// percent-to-count function of the GC window histogram.
// No dependencies.
package gwh_pkg;

   localparam int NUM_WINDOWS   = 4;
   localparam int MAX_STEPS     = 256;   // power of two: ring pointers wrap by truncation
   localparam int NUM_BINS      = 100;
   localparam int NUM_GROUPS    = 8;
   localparam int STEP_BP       = 5;
   localparam int NUM_WIN_REGS  = 4;
   localparam int DEFAULT_STEPS = 20;

   localparam int CMD_W  = 2;
   localparam int GSEL_W = 3;
   localparam int POS_W  = 32;
   localparam int PCT_W  = 7;
   localparam int WSEL_W = 2;
   localparam int BSEL_W = 7;
   localparam int MASK_W = 4;
   localparam int CNTR_W = 32;

   localparam int ACT_W   = 3;
   localparam int STEPS_W = 9;
   localparam int CSR_W   = 9;
   localparam int CIDX_W  = 3;

   localparam int PCT_MAX  = 2 ** PCT_W - 1;
   localparam int CNT_MAX  = PCT_MAX * STEP_BP / 100;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);
   localparam int LEN_W    = $clog2(MAX_STEPS + 1);
   localparam int PTR_W    = $clog2(MAX_STEPS);
   localparam int WIN_W    = $clog2(NUM_WINDOWS);
   localparam int NWIN_W   = $clog2(NUM_WINDOWS + 1);
   localparam int SUM_W    = $clog2(MAX_STEPS * CNT_MAX + 1);
   localparam int DVD_W    = $clog2(MAX_STEPS * CNT_MAX * NUM_BINS + 1);
   localparam int DVS_W    = $clog2(MAX_STEPS * STEP_BP + 2);
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int GRP_W    = $clog2(NUM_GROUPS);
   localparam int HIST_DEPTH = NUM_GROUPS * NUM_WINDOWS * NUM_BINS;
   localparam int HADDR_W  = $clog2(HIST_DEPTH);
   localparam int RING_DEPTH = NUM_WINDOWS * MAX_STEPS;
   localparam int RADDR_W  = WIN_W + PTR_W;
   localparam int END_W    = POS_W + 1;

   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [CIDX_W-1:0] CSR_ACTIVE = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_WIN_A  = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_WIN_B  = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_WIN_C  = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_WIN_D  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [GSEL_W-1:0] group_sel;
      logic [POS_W-1:0]  position;
      logic [PCT_W-1:0]  gc_percent;
      logic [WSEL_W-1:0] window_sel;
      logic [BSEL_W-1:0] bin_sel;
   } item_type;

   typedef struct packed {
      logic              kind;
      logic [MASK_W-1:0] recorded_mask;
      logic [CNTR_W-1:0] bin_count;
   } res_type;

   typedef struct packed {
      logic [ACT_W-1:0]                     active_windows;
      logic [NUM_WIN_REGS-1:0][STEPS_W-1:0] win_steps;
   } cfg_type;

   // GC bases in one step: floor(pct * STEP_BP / 100), as a threshold count
   function automatic logic [CNT_W-1:0] gc_count(input logic [PCT_W-1:0] pct);
      int prod;
      int c;
      prod = int'(pct) * STEP_BP;
      c = 0;
      for (int k = 1; k <= CNT_MAX; k++) begin
         if (prod >= 100 * k) c = c + 1;
      end
      return CNT_W'(c);
   endfunction

endpackage

FILE: hdl/gwh_divider.sv
// gwh_divider: restoring divider, one quotient bit per cycle.
// Depends on gwh_pkg.
module gwh_divider import gwh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int ITER_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    shifted;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      iter_in = iter_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         iter_in = ITER_W'(DVD_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = ge ? DVS_W'(shifted - {1'b0, dvs_ff}) : DVS_W'(shifted);
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/gwh_core.sv
// gwh_core: sequencer over windows, step ring memory, histogram memory
// and the shared divider. Depends on gwh_pkg and gwh_divider.
module gwh_core import gwh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     start,
   input  item_type item,
   output logic     busy,
   output logic     res_valid,
   output res_type  res,
   input  logic     res_take
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd2;
   localparam logic [3:0] S_RRD  = 4'd3;
   localparam logic [3:0] S_RDAT = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_TRIM = 4'd6;
   localparam logic [3:0] S_SUB  = 4'd7;
   localparam logic [3:0] S_PUSH = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_HRD  = 4'd10;
   localparam logic [3:0] S_HWR  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0]         state_ff, state_in;
   item_type           item_ff, item_in;
   res_type            res_ff, res_in;
   logic [GRP_W-1:0]   group_ff, group_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HADDR_W-1:0] haddr_ff, haddr_in;

   logic [PTR_W-1:0]   head_ff [NUM_WINDOWS];
   logic [PTR_W-1:0]   head_in [NUM_WINDOWS];
   logic [LEN_W-1:0]   fill_ff [NUM_WINDOWS];
   logic [LEN_W-1:0]   fill_in [NUM_WINDOWS];
   logic [SUM_W-1:0]   sum_ff  [NUM_WINDOWS];
   logic [SUM_W-1:0]   sum_in  [NUM_WINDOWS];
   logic [END_W-1:0]   last_ff [NUM_WINDOWS];
   logic [END_W-1:0]   last_in [NUM_WINDOWS];
   logic [NUM_WINDOWS-1:0] evalid_ff, evalid_in;

   logic [CNT_W-1:0]   ring_ff [RING_DEPTH];
   logic [CNT_W-1:0]   ring_q_ff;
   logic [CNTR_W-1:0]  hist_ff [HIST_DEPTH];
   logic [CNTR_W-1:0]  hist_q_ff;

   logic               ring_we;
   logic               hist_we;
   logic [CNTR_W-1:0]  hist_wdata;
   logic [RADDR_W-1:0] ring_waddr, ring_raddr;

   logic [STEPS_W-1:0] raw_len;
   logic [LEN_W-1:0]   len_w;
   logic [NWIN_W-1:0]  n_act;
   logic               last_win;
   logic               contig;
   logic [SUM_W-1:0]   sum_new;
   logic [LEN_W-1:0]   fill_new;
   logic               div_start;
   logic [DVD_W-1:0]   div_dvd;
   logic [DVS_W-1:0]   div_dvs;
   logic               div_done;
   logic [DVD_W-1:0]   div_quo;
   logic [BIN_W-1:0]   bin_clamped;
   logic [HADDR_W-1:0] sample_addr;
   logic [HADDR_W-1:0] read_addr;
   logic [GRP_W-1:0]   start_group;

   assign raw_len = cfg.win_steps[win_ff];
   always_comb begin
      if (raw_len == '0)
         len_w = LEN_W'(1);
      else if (int'(raw_len) > MAX_STEPS)
         len_w = LEN_W'(MAX_STEPS);
      else
         len_w = LEN_W'(raw_len);
   end

   always_comb begin
      if (cfg.active_windows == '0)
         n_act = NWIN_W'(1);
      else if (int'(cfg.active_windows) > NUM_WINDOWS)
         n_act = NWIN_W'(NUM_WINDOWS);
      else
         n_act = NWIN_W'(cfg.active_windows);
   end

   assign last_win = ({1'b0, win_ff} == NWIN_W'(n_act - NWIN_W'(1)));
   assign contig   = ({1'b0, last_ff[win_ff]} + (END_W + 1)'(1))
                     == (END_W + 1)'(item_ff.position);
   assign sum_new  = sum_ff[win_ff] + SUM_W'(cnt_ff);
   assign fill_new = fill_ff[win_ff] + LEN_W'(1);
   assign div_dvd  = DVD_W'(sum_new) * DVD_W'(NUM_BINS);
   assign div_dvs  = DVS_W'(len_w) * DVS_W'(STEP_BP) + DVS_W'(1);

   assign bin_clamped = (div_quo > DVD_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                        : BIN_W'(div_quo);
   assign sample_addr = HADDR_W'((int'(group_ff) * NUM_WINDOWS + int'(win_ff)) * NUM_BINS
                                 + int'(bin_clamped));
   assign read_addr   = HADDR_W'((int'(item_ff.group_sel) * NUM_WINDOWS
                                  + int'(item_ff.window_sel)) * NUM_BINS
                                 + int'(item_ff.bin_sel));
   assign start_group = (int'(item_ff.group_sel) >= NUM_GROUPS) ? GRP_W'(NUM_GROUPS - 1)
                                                                : GRP_W'(item_ff.group_sel);

   assign ring_waddr = {win_ff, head_ff[win_ff]};
   // oldest entry: head minus fill, wrapped by the ring size
   assign ring_raddr = {win_ff, PTR_W'(head_ff[win_ff] - PTR_W'(fill_ff[win_ff]))};

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      res_in     = res_ff;
      group_in   = group_ff;
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      haddr_in   = haddr_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      last_in    = last_ff;
      evalid_in  = evalid_ff;
      ring_we    = 1'b0;
      hist_we    = 1'b0;
      hist_wdata = '0;
      div_start  = 1'b0;

      case (state_ff)
         S_CLR: begin
            hist_we = 1'b1;
            if (haddr_ff == HADDR_W'(HIST_DEPTH - 1))
               state_in = S_IDLE;
            else
               haddr_in = haddr_ff + HADDR_W'(1);
         end
         S_IDLE: begin
            if (start) begin
               item_in  = item;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_in = '0;
            case (item_ff.cmd)
               CMD_START: begin
                  group_in = start_group;
                  for (int w = 0; w < NUM_WINDOWS; w++) begin
                     head_in[w] = '0;
                     fill_in[w] = '0;
                     sum_in[w]  = '0;
                  end
                  evalid_in = '0;
                  state_in  = S_DONE;
               end
               CMD_SAMPLE: begin
                  cnt_in   = gc_count(item_ff.gc_percent);
                  win_in   = '0;
                  state_in = S_CHK;
               end
               CMD_READ: begin
                  res_in.kind = 1'b1;
                  if (int'(item_ff.bin_sel) < NUM_BINS) begin
                     haddr_in = read_addr;
                     state_in = S_RRD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RRD: state_in = S_RDAT;
         S_RDAT: begin
            res_in.bin_count = hist_q_ff;
            state_in = S_DONE;
         end
         S_CHK: begin
            if (evalid_ff[win_ff] && !contig) begin
               head_in[win_ff]   = '0;
               fill_in[win_ff]   = '0;
               sum_in[win_ff]    = '0;
               evalid_in[win_ff] = 1'b0;
            end
            state_in = S_TRIM;
         end
         S_TRIM: begin
            if (fill_ff[win_ff] >= len_w)
               state_in = S_SUB;
            else
               state_in = S_PUSH;
         end
         S_SUB: begin
            sum_in[win_ff]  = sum_ff[win_ff] - SUM_W'(ring_q_ff);
            fill_in[win_ff] = fill_ff[win_ff] - LEN_W'(1);
            state_in = S_TRIM;
         end
         S_PUSH: begin
            ring_we           = 1'b1;
            head_in[win_ff]   = head_ff[win_ff] + PTR_W'(1);
            fill_in[win_ff]   = fill_new;
            sum_in[win_ff]    = sum_new;
            last_in[win_ff]   = END_W'(item_ff.position) + END_W'(STEP_BP - 1);
            evalid_in[win_ff] = 1'b1;
            if (fill_new == len_w) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (last_win) begin
               state_in = S_DONE;
            end else begin
               win_in   = win_ff + WIN_W'(1);
               state_in = S_CHK;
            end
         end
         S_DIV: begin
            if (div_done) begin
               haddr_in = sample_addr;
               state_in = S_HRD;
            end
         end
         S_HRD: state_in = S_HWR;
         S_HWR: begin
            hist_we    = 1'b1;
            hist_wdata = (&hist_q_ff) ? hist_q_ff : hist_q_ff + CNTR_W'(1);
            res_in.recorded_mask[win_ff] = 1'b1;
            if (last_win) begin
               state_in = S_DONE;
            end else begin
               win_in   = win_ff + WIN_W'(1);
               state_in = S_CHK;
            end
         end
         S_DONE: begin
            if (res_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         haddr_ff  <= '0;
         group_ff  <= '0;
         win_ff    <= '0;
         evalid_ff <= '0;
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            head_ff[w] <= '0;
            fill_ff[w] <= '0;
            sum_ff[w]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         haddr_ff  <= haddr_in;
         group_ff  <= group_in;
         win_ff    <= win_in;
         evalid_ff <= evalid_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_ff[ring_waddr] <= cnt_ff;
      ring_q_ff <= ring_ff[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_ff[haddr_ff] <= hist_wdata;
      hist_q_ff <= hist_ff[haddr_ff];
   end

   gwh_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

FILE: hdl/gc_window_histogram.sv
// gc_window_histogram: top level; configuration registers, input capture,
// output word register. Depends on gwh_pkg and gwh_core.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | cmd, group, position, percent, window, bin
//   rsp_    | out       | rsp_valid/rsp_stall | kind, recorded mask, bin count
//   csr_    | in        | csr_wen             | index, data (no read-back)
//
// Sequence: a sample visits each active window in turn, drops the oldest
// steps from the ring until there is room, pushes the new step and, when
// the window is full, runs the shared restoring divider (18 quotient bits)
// and the histogram read-modify-write.
// Reset: synchronous; afterwards the histogram memory's 3200 entries are
// zeroed one entry a cycle, with req_stall high. Configuration writes are
// taken during that pass.
// Stalls: a finished word sits in the output register; the next request
// is accepted meanwhile, and the core holds its result until the output
// register frees.
module gc_window_histogram import gwh_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [GSEL_W-1:0] req_group_sel,
   input  logic [POS_W-1:0]  req_position,
   input  logic [PCT_W-1:0]  req_gc_percent,
   input  logic [WSEL_W-1:0] req_window_sel,
   input  logic [BSEL_W-1:0] req_bin_sel,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [MASK_W-1:0] rsp_recorded_mask,
   output logic [CNTR_W-1:0] rsp_bin_count,

   input  logic              csr_wen,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     rsp_valid_ff, rsp_valid_in;
   res_type  rsp_ff, rsp_in;

   item_type item;
   logic     core_busy;
   logic     core_res_valid;
   res_type  core_res;
   logic     res_take;
   logic     start;

   // config writes: out-of-list indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ACTIVE: cfg_in.active_windows = csr_wdata[ACT_W-1:0];
            CSR_WIN_A:  cfg_in.win_steps[0]   = csr_wdata[STEPS_W-1:0];
            CSR_WIN_B:  cfg_in.win_steps[1]   = csr_wdata[STEPS_W-1:0];
            CSR_WIN_C:  cfg_in.win_steps[2]   = csr_wdata[STEPS_W-1:0];
            CSR_WIN_D:  cfg_in.win_steps[3]   = csr_wdata[STEPS_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   assign item.cmd        = req_cmd;
   assign item.group_sel  = req_group_sel;
   assign item.position   = req_position;
   assign item.gc_percent = req_gc_percent;
   assign item.window_sel = req_window_sel;
   assign item.bin_sel    = req_bin_sel;

   assign req_stall = core_busy;
   assign start     = req_valid && !core_busy;

   // output word register loads a finished core result whenever it is empty or being drained
   assign res_take = core_res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_in       = core_res;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_windows <= ACT_W'(1);
         for (int i = 0; i < NUM_WIN_REGS; i++)
            cfg_ff.win_steps[i] <= STEPS_W'(DEFAULT_STEPS);
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   gwh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .item      (item),
      .busy      (core_busy),
      .res_valid (core_res_valid),
      .res       (core_res),
      .res_take  (res_take)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_recorded_mask = rsp_ff.recorded_mask;
   assign rsp_bin_count     = rsp_ff.bin_count;

endmodule

FILE: hdl/gwh_checker.sv
// gwh_checker: port-level assertions for gc_window_histogram, bound to it.
// Depends on gwh_pkg.
module gwh_checker import gwh_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_kind,
   input logic [MASK_W-1:0] rsp_recorded_mask,
   input logic [CNTR_W-1:0] rsp_bin_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_count) && $stable(rsp_kind)
                                 && $stable(rsp_recorded_mask))
      else $error("rsp word changed while stalled");

   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during histogram clear");

   a_ack_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_bin_count == '0)
      else $error("acknowledge word carries a count");

   a_read_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_recorded_mask == '0)
      else $error("read word carries a mask");

endmodule

bind gc_window_histogram gwh_checker u_gwh_checker (.*);

FILE: bench/gc_window_histogram_test.sv
// gc_window_histogram_test: self-checking bench for the GC window histogram.
// Depends on gwh_pkg and gc_window_histogram; carries its own window/histogram predictor.
`timescale 1ns / 100ps

module gc_window_histogram_test;
   import gwh_pkg::*;

   // codes the package leaves unnamed
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic             KIND_ACK    = 1'b0;
   localparam logic             KIND_DATA   = 1'b1;
   localparam int               CYCLE_LIMIT = 3000000;
   localparam int               LONG_HOLD   = 400;
   localparam int               ITEM_W      = $bits(item_type);

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd;
   logic [GSEL_W-1:0] req_group_sel;
   logic [POS_W-1:0]  req_position;
   logic [PCT_W-1:0]  req_gc_percent;
   logic [WSEL_W-1:0] req_window_sel;
   logic [BSEL_W-1:0] req_bin_sel;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_kind;
   logic [MASK_W-1:0] rsp_recorded_mask;
   logic [CNTR_W-1:0] rsp_bin_count;
   logic              csr_wen;
   logic [CIDX_W-1:0] csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   gc_window_histogram dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the registers and windows
   // ---------------------------------------------------------------
   logic [ACT_W-1:0]   act_reg;
   logic [STEPS_W-1:0] steps_reg [NUM_WIN_REGS];
   logic [2:0]         cur_group;
   logic [2:0]         step_cnt [NUM_WINDOWS][MAX_STEPS];
   int                 head [NUM_WINDOWS];
   int                 fill [NUM_WINDOWS];
   int                 gc_sum [NUM_WINDOWS];
   logic [END_W-1:0]   last_end [NUM_WINDOWS];
   bit                 end_ok [NUM_WINDOWS];
   int unsigned        hist [HIST_DEPTH];

   item_type pending_words [$];   // filled by the stimulus block, drained by the driver
   res_type  expected_words [$];  // predicted responses, oldest first

   int  failures = 0;
   int  cycles = 0;
   int  n_start = 0, n_sample = 0, n_read = 0, n_binned = 0;
   bit  took = 1'b0;
   bit  calm = 1'b0;              // no idling on either side
   bit  long_req = 1'b0;          // asks the receiver for one long hold-off

   function automatic void clear_win(int w);
      head[w] = 0; fill[w] = 0; gc_sum[w] = 0; last_end[w] = '0; end_ok[w] = 1'b0;
   endfunction

   function automatic int win_len(int w);
      int s;
      s = (w < NUM_WIN_REGS) ? int'(steps_reg[w]) : DEFAULT_STEPS;
      if (s == 0) s = 1;
      if (s > MAX_STEPS) s = MAX_STEPS;
      return s;
   endfunction

   // push one step into window w; returns 1 when the window was exactly full and binned
   function automatic bit slide_window(int w, logic [POS_W-1:0] pos, int cnt);
      int len, oldest, bin, idx;
      len = win_len(w);
      if (end_ok[w] && {1'b0, pos} != last_end[w] + 1) clear_win(w);
      while (fill[w] >= len) begin
         oldest = (head[w] + MAX_STEPS - fill[w]) % MAX_STEPS;
         gc_sum[w] -= step_cnt[w][oldest];
         fill[w]--;
      end
      step_cnt[w][head[w]] = cnt[2:0];
      head[w] = (head[w] + 1) % MAX_STEPS;
      fill[w]++;
      gc_sum[w] += cnt;
      last_end[w] = {1'b0, pos} + END_W'(STEP_BP - 1);
      end_ok[w] = 1'b1;
      if (fill[w] != len) return 1'b0;
      bin = (gc_sum[w] * NUM_BINS) / (len * STEP_BP + 1);
      if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
      idx = (int'(cur_group) * NUM_WINDOWS + w) * NUM_BINS + bin;
      if (hist[idx] != 32'hFFFF_FFFF) hist[idx]++;
      return 1'b1;
   endfunction

   function automatic res_type predict_response(item_type it);
      res_type r;
      int n, cnt;
      r = '0;
      r.kind = KIND_ACK;
      case (it.cmd)
         CMD_START: begin
            cur_group = (it.group_sel < NUM_GROUPS) ? it.group_sel : 3'(NUM_GROUPS - 1);
            for (int w = 0; w < NUM_WINDOWS; w++) clear_win(w);
         end
         CMD_SAMPLE: begin
            cnt = int'(it.gc_percent) * STEP_BP / 100;
            n = int'(act_reg);
            if (n == 0) n = 1;
            if (n > NUM_WINDOWS) n = NUM_WINDOWS;
            for (int w = 0; w < n; w++)
               if (slide_window(w, it.position, cnt)) r.recorded_mask[w] = 1'b1;
         end
         CMD_READ: begin
            r.kind = KIND_DATA;
            if (it.group_sel < NUM_GROUPS && it.window_sel < NUM_WINDOWS
                && it.bin_sel < NUM_BINS)
               r.bin_count = hist[(int'(it.group_sel) * NUM_WINDOWS + int'(it.window_sel))
                                  * NUM_BINS + int'(it.bin_sel)];
         end
         default: ;  // unknown command: plain acknowledge, no state change
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: changes at the falling edge, holds while stalled
   // ---------------------------------------------------------------
   int gap_left = 0;
   always @(negedge clock) begin
      item_type it;
      int r;
      if (!reset && !(req_valid && !took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            it = pending_words[0];
            pending_words.delete(0);
            req_cmd <= it.cmd;
            req_group_sel <= it.group_sel;
            req_position <= it.position;
            req_gc_percent <= it.gc_percent;
            req_window_sel <= it.window_sel;
            req_bin_sel <= it.bin_sel;
            req_valid <= 1'b1;
            // mostly back to back, sometimes short gaps, rarely a long one
            r = $urandom_range(0, 99);
            if (calm || r < 65) gap_left = 0;
            else if (r < 95) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(10, 40);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response stall: random short/long stalls plus one long hold-off
   // ---------------------------------------------------------------
   int stall_left = 0, free_left = 0, hold_left = 0;
   always @(negedge clock) begin
      int r;
      if (long_req) begin
         hold_left = LONG_HOLD;
         long_req = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) free_left = $urandom_range(0, 12);
         else if (r < 92) stall_left = $urandom_range(0, 2);
         else stall_left = $urandom_range(9, 39);
         rsp_stall <= (r >= 50);
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each response
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      item_type it;
      res_type  want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $realtime, expected_words.size());
         $display("TEST FAILED");
         $finish;
      end
      took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            took = 1'b1;
            it = '{req_cmd, req_group_sel, req_position, req_gc_percent,
                   req_window_sel, req_bin_sel};
            want = predict_response(it);
            expected_words.insert(expected_words.size(), want);
            case (it.cmd)
               CMD_START:  n_start++;
               CMD_SAMPLE: begin
                  n_sample++;
                  if (want.recorded_mask != 0) n_binned++;
               end
               CMD_READ:   n_read++;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               failures++;
               $display("%0t: unexpected response kind=%0d mask=%h count=%0d", $realtime,
                        rsp_kind, rsp_recorded_mask, rsp_bin_count);
            end else begin
               want = expected_words[0];
               expected_words.delete(0);
               if (rsp_kind !== want.kind) begin
                  failures++;
                  $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, rsp_kind);
               end
               if (rsp_recorded_mask !== want.recorded_mask) begin
                  failures++;
                  $display("%0t: recorded_mask expected %h actual %h", $realtime,
                           want.recorded_mask, rsp_recorded_mask);
               end
               if (rsp_bin_count !== want.bin_count) begin
                  failures++;
                  $display("%0t: bin_count expected %0d actual %0d", $realtime,
                           want.bin_count, rsp_bin_count);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [POS_W-1:0] next_pos;
   logic [2:0]       gen_group;

   // unused fields carry random bits so every input bit toggles
   task automatic add_word(logic [CMD_W-1:0] cmd, logic [GSEL_W-1:0] grp,
                           logic [POS_W-1:0] pos, logic [PCT_W-1:0] pct,
                           logic [WSEL_W-1:0] wsel, logic [BSEL_W-1:0] bsel);
      item_type it;
      it = ITEM_W'({$urandom, $urandom});
      it.cmd = cmd;
      case (cmd)
         CMD_START: it.group_sel = grp;
         CMD_SAMPLE: begin
            it.position = pos;
            it.gc_percent = pct;
         end
         CMD_READ: begin
            it.group_sel = grp;
            it.window_sel = wsel;
            it.bin_sel = bsel;
         end
         default: ;
      endcase
      pending_words.insert(pending_words.size(), it);
   endtask

   // wait until all words are sent and all responses checked, then idle before the next phase
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      if (idx == CSR_ACTIVE) act_reg = ACT_W'(val);
      else steps_reg[idx - 1] = STEPS_W'(val);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_windows(int act, int a, int b, int c, int d);
      write_reg(CSR_ACTIVE, act);
      write_reg(CSR_WIN_A, a);
      write_reg(CSR_WIN_B, b);
      write_reg(CSR_WIN_C, c);
      write_reg(CSR_WIN_D, d);
   endtask

   // noise: percent of words that are not samples; jump_pm: per mille position jumps
   task automatic random_words(int n, int noise, int jump_pm);
      int r;
      logic [PCT_W-1:0] pct;
      logic [GSEL_W-1:0] grp;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < noise) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               grp = GSEL_W'($urandom);
               gen_group = grp;
               add_word(CMD_START, grp, '0, '0, '0, '0);
            end else if (r < 90) begin
               grp = ($urandom_range(0, 3) != 0) ? gen_group : 3'($urandom);
               add_word(CMD_READ, grp, '0, '0, WSEL_W'($urandom),
                        ($urandom_range(0, 9) != 0) ? 7'($urandom_range(0, 99)) : 7'($urandom));
            end else begin
               add_word(CMD_UNKNOWN, '0, '0, '0, '0, '0);
            end
         end else begin
            if ($urandom_range(0, 999) < jump_pm) next_pos = $urandom;
            pct = ($urandom_range(0, 9) != 0) ? 7'($urandom_range(0, 100)) : 7'($urandom);
            add_word(CMD_SAMPLE, '0, next_pos, pct, '0, '0);
            next_pos += STEP_BP;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0; req_group_sel = '0; req_position = '0; req_gc_percent = '0;
      req_window_sel = '0; req_bin_sel = '0;
      rsp_stall = 1'b0;
      csr_wen = 1'b0; csr_index = '0; csr_wdata = '0;
      act_reg = 3'd1;
      for (int i = 0; i < NUM_WIN_REGS; i++) steps_reg[i] = STEPS_W'(DEFAULT_STEPS);
      cur_group = '0;
      gen_group = '0;
      next_pos = '0;
      for (int w = 0; w < NUM_WINDOWS; w++) clear_win(w);
      foreach (hist[i]) hist[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short windows so the directed words already bin
      set_windows(4, 1, 2, 1, 3);
      add_word(CMD_START, 3'd0, '0, '0, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'd0, 7'd0, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'd5, 7'd100, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'd10, 7'd127, '0, '0);   // percent over 100
      add_word(CMD_SAMPLE, '0, 32'd15, 7'd20, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'd15, 7'd4, '0, '0);     // repeated position: gap
      add_word(CMD_START, 3'd7, '0, '0, '0, '0);          // leftover group
      add_word(CMD_SAMPLE, '0, 32'hFFFF_FFF6, 7'd100, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'hFFFF_FFFB, 7'd100, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'd0, 7'd99, '0, '0);     // wrap is never contiguous
      add_word(CMD_SAMPLE, '0, 32'd5, 7'd1, '0, '0);
      add_word(CMD_START, 3'd3, '0, '0, '0, '0);
      add_word(CMD_SAMPLE, '0, 32'h8000_0000, 7'd60, '0, '0);
      add_word(CMD_UNKNOWN, '1, '1, '1, '1, '1);
      add_word(CMD_READ, 3'd0, '0, '0, 2'd0, 7'd0);
      add_word(CMD_READ, 3'd0, '0, '0, 2'd1, 7'd99);
      add_word(CMD_READ, 3'd0, '0, '0, 2'd3, 7'd99);
      add_word(CMD_READ, 3'd7, '0, '0, 2'd2, 7'd99);
      add_word(CMD_READ, 3'd7, '0, '0, 2'd0, 7'd100);     // bin out of range
      add_word(CMD_READ, 3'd7, '0, '0, 2'd3, 7'd127);
      add_word(CMD_READ, 3'd3, '0, '0, 2'd0, 7'd59);
      add_word(CMD_READ, 3'd0, '0, '0, 2'd2, 7'd0);
      gen_group = 3'd3;
      next_pos = 32'h8000_0005;
      random_words(120, 15, 20);
      drain();

      // reset-like lengths, no idling anywhere
      set_windows(1, 20, 20, 20, 20);
      calm = 1'b1;
      random_words(100, 10, 10);
      drain();
      calm = 1'b0;

      // longest windows; active count above the window count
      set_windows(7, 256, 511, 7, 4);
      add_word(CMD_START, 3'd5, '0, '0, '0, '0);
      gen_group = 3'd5;
      random_words(300, 2, 0);
      drain();

      // shrink the full windows without a start; receiver holds off meanwhile
      set_windows(3, 2, 1, 9, 0);
      long_req = 1'b1;
      random_words(120, 12, 15);
      drain();

      // active count zero
      set_windows(0, 5, 3, 2, 6);
      random_words(120, 12, 15);
      drain();

      set_windows(5, 3, 6, 2, 8);
      random_words(120, 15, 20);
      drain();

      $display("covered %0d starts, %0d samples (%0d binned), %0d reads",
               n_start, n_sample, n_binned, n_read);
      $display("window lengths 0..511, active counts 0..7, wrap, shrink, out-of-range reads");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
